// ===== src/sfs_pkg.sv =====
`timescale 1ns / 1ps

package sfs_pkg;

    // Header bytes held on chip for the early fields and small collection offsets
    localparam int unsigned HDR_BYTES   = 20;
    localparam int unsigned ENTRY_BYTES = 16;
    localparam int unsigned DIR_START   = 12;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    // Register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TABLES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_WINDOW = 1'd1;

    localparam logic [15:0] MAX_TABLES_RST  = 16'd100;
    localparam logic [15:0] SCAN_WINDOW_RST = 16'd512;

    // Signatures and table tags, big-endian
    localparam logic [31:0] SIG_TTCF = 32'h7474_6366;
    localparam logic [31:0] SIG_OTTO = 32'h4F54_544F;
    localparam logic [31:0] SIG_TRUE = 32'h7472_7565;
    localparam logic [31:0] SIG_TT10 = 32'h0001_0000;
    localparam logic [31:0] GLYF_TAG = 32'h676C_7966;
    localparam logic [31:0] CFF_TAG  = 32'h4346_4620;
    localparam logic [31:0] CFF2_TAG = 32'h4346_4632;
    localparam logic [31:0] POS_MAX  = 32'hFFFF_FFFF;

    // Format codes
    localparam logic [2:0] FMT_UNKNOWN = 3'd0;
    localparam logic [2:0] FMT_TTF     = 3'd1;
    localparam logic [2:0] FMT_OTF     = 3'd2;
    localparam logic [2:0] FMT_TTC     = 3'd3;
    localparam logic [2:0] FMT_OTC     = 3'd4;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // Everything the decision needs, with the current byte already folded in
    typedef struct packed {
        logic [HDR_BYTES-1:0][7:0] hdr;
        logic [31:0]               pos;
        logic                      glyf;
        logic                      cff;
        logic [31:0]               cap;
        logic [15:0]               max_tables;
        logic [15:0]               scan_window;
    } view_t;

    typedef struct packed {
        logic [2:0]  format;
        logic [31:0] font_count;
    } result_t;

endpackage

// ===== src/sfs_scan.sv =====
`timescale 1ns / 1ps

module sfs_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  sfs_pkg::cfg_wr_t  cfg,
    input  logic              fire,
    input  logic [7:0]        data_byte,
    input  logic              last,
    output sfs_pkg::view_t    view
);
    import sfs_pkg::*;

    logic [31:0]               pos_reg;
    logic [31:0]               pos_next;
    logic [HDR_BYTES-1:0][7:0] hdr_reg;
    logic [HDR_BYTES-1:0][7:0] hv;
    logic [31:0]               tag_reg;
    logic [31:0]               tag_next;
    logic                      glyf_reg;
    logic                      glyf_next;
    logic                      cff_reg;
    logic                      cff_next;
    logic [31:0]               cap_reg;
    logic [31:0]               cap_next;
    logic [15:0]               cfg_max_reg;
    logic [15:0]               cfg_win_reg;
    logic [15:0]               lat_max_reg;
    logic [15:0]               lat_max_next;
    logic [15:0]               lat_win_reg;
    logic [15:0]               lat_win_next;
    logic [15:0]               n_tables;
    logic [31:0]               off;
    logic [31:0]               off_dist;
    logic                      dir_slot;
    logic                      in_count;
    logic                      in_win;
    logic                      dir_take;
    logic                      cap_hit;
    logic                      first;

    assign first = (pos_reg == 32'd0);

    // Bytes beyond the current position read as zero for this file; the byte at it is the incoming byte
    always_comb
    begin
        for (int k = 0; k < HDR_BYTES; k++)
        begin
            if (32'(k) < pos_reg)
                hv[k] = hdr_reg[k];
            else if (32'(k) == pos_reg)
                hv[k] = data_byte;
            else
                hv[k] = 8'h00;
        end
    end

    assign n_tables = {hv[4], hv[5]};
    assign off      = {hv[12], hv[13], hv[14], hv[15]};
    assign tag_next = {tag_reg[23:0], data_byte};

    // A tag completes at byte 15 of the file and every 16 bytes after it
    assign dir_slot = &pos_reg[3:0];
    assign in_count = pos_reg[31:4] < {12'd0, n_tables};
    assign in_win   = ({1'b0, pos_reg} + 33'd13) <= {17'd0, lat_win_reg};
    assign dir_take = dir_slot && in_count && in_win;

    assign off_dist = pos_reg - off;
    assign cap_hit  = (pos_reg >= 32'd16) && (pos_reg >= off) && (off_dist < 32'd4);

    always_comb
    begin
        if (first)
        begin
            glyf_next    = 1'b0;
            cff_next     = 1'b0;
            cap_next     = 32'd0;
            lat_max_next = cfg_max_reg;
            lat_win_next = cfg_win_reg;
        end
        else
        begin
            glyf_next    = glyf_reg || (dir_take && tag_next == GLYF_TAG);
            cff_next     = cff_reg
                           || (dir_take && (tag_next == CFF_TAG || tag_next == CFF2_TAG));
            cap_next     = cap_hit ? {cap_reg[23:0], data_byte} : cap_reg;
            lat_max_next = lat_max_reg;
            lat_win_next = lat_win_reg;
        end
    end

    always_comb
    begin
        if (last)
            pos_next = 32'd0;
        else if (pos_reg != POS_MAX)
            pos_next = pos_reg + 32'd1;
        else
            pos_next = pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 32'd0;
            glyf_reg    <= 1'b0;
            cff_reg     <= 1'b0;
            cfg_max_reg <= MAX_TABLES_RST;
            cfg_win_reg <= SCAN_WINDOW_RST;
            lat_max_reg <= MAX_TABLES_RST;
            lat_win_reg <= SCAN_WINDOW_RST;
        end
        else
        begin
            if (cfg.we)
            begin
                unique case (cfg.index)
                    REG_MAX_TABLES:  cfg_max_reg <= cfg.data;
                    REG_SCAN_WINDOW: cfg_win_reg <= cfg.data;
                    default:         ;
                endcase
            end
            if (fire)
            begin
                pos_reg     <= pos_next;
                glyf_reg    <= glyf_next;
                cff_reg     <= cff_next;
                lat_max_reg <= lat_max_next;
                lat_win_reg <= lat_win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            tag_reg <= tag_next;
            cap_reg <= cap_next;
            for (int k = 0; k < HDR_BYTES; k++)
            begin
                if (32'(k) == pos_reg)
                    hdr_reg[k] <= data_byte;
            end
        end
    end

    assign view.hdr         = hv;
    assign view.pos         = pos_reg;
    assign view.glyf        = glyf_next;
    assign view.cff         = cff_next;
    assign view.cap         = cap_next;
    assign view.max_tables  = lat_max_next;
    assign view.scan_window = lat_win_next;

endmodule

// ===== src/sfs_decide.sv =====
`timescale 1ns / 1ps

module sfs_decide (
    input  sfs_pkg::view_t   view,
    output sfs_pkg::result_t res
);
    import sfs_pkg::*;

    logic [31:0] sig;
    logic [31:0] fc;
    logic [31:0] off;
    logic [15:0] n_tables;
    logic [31:0] sel;
    logic [31:0] coll_sig;
    logic [20:0] need;
    logic [20:0] win_ext;
    logic [20:0] scan_len;
    logic        coll_ok;
    logic        dir_ok;
    logic [2:0]  sig_fmt;

    assign sig      = {view.hdr[0], view.hdr[1], view.hdr[2], view.hdr[3]};
    assign fc       = {view.hdr[8], view.hdr[9], view.hdr[10], view.hdr[11]};
    assign off      = {view.hdr[12], view.hdr[13], view.hdr[14], view.hdr[15]};
    assign n_tables = {view.hdr[4], view.hdr[5]};

    // Signature of the first font when it sits inside the header store
    always_comb
    begin
        sel = 32'd0;
        for (int o = 0; o <= HDR_BYTES - 4; o++)
        begin
            if (off == 32'(o))
                sel = {view.hdr[o], view.hdr[o+1], view.hdr[o+2], view.hdr[o+3]};
        end
    end

    assign coll_sig = (off <= 32'(HDR_BYTES - 4)) ? sel : view.cap;
    assign coll_ok  = (fc != 32'd0) && (view.pos >= 32'd15) && !off[31]
                      && ({1'b0, view.pos} >= ({1'b0, off} + 33'd3));

    assign need     = 21'(DIR_START) + {1'b0, n_tables, 4'd0};
    assign win_ext  = {5'd0, view.scan_window};
    assign scan_len = (need > win_ext) ? win_ext : need;
    assign dir_ok   = (n_tables != 16'd0) && (n_tables <= view.max_tables)
                      && (scan_len >= 21'(DIR_START + ENTRY_BYTES))
                      && (({1'b0, view.pos} + 33'd1) >= {12'd0, scan_len});

    always_comb
    begin
        if (sig == SIG_TT10 || sig == SIG_TRUE)
            sig_fmt = FMT_TTF;
        else if (sig == SIG_OTTO)
            sig_fmt = FMT_OTF;
        else
            sig_fmt = FMT_UNKNOWN;
    end

    always_comb
    begin
        res.format     = FMT_UNKNOWN;
        res.font_count = 32'd0;
        if (view.pos < 32'd11)
        begin
            res.format     = FMT_UNKNOWN;
        end
        else if (sig == SIG_TTCF)
        begin
            if (coll_ok)
            begin
                res.format     = (coll_sig == SIG_OTTO) ? FMT_OTC : FMT_TTC;
                res.font_count = fc;
            end
        end
        else if (sig_fmt != FMT_UNKNOWN)
        begin
            res.format     = sig_fmt;
            res.font_count = 32'd1;
            if (dir_ok && view.glyf && !view.cff)
                res.format = FMT_TTF;
            else if (dir_ok && view.cff && !view.glyf)
                res.format = FMT_OTF;
        end
    end

endmodule

// ===== src/sfs_outq.sv =====
`timescale 1ns / 1ps

module sfs_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sfs_pkg::result_t  push_res,
    output logic              room,
    output logic              valid,
    input  logic              stall,
    output sfs_pkg::result_t  head
);
    import sfs_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    slot0_reg;
    result_t    slot1_reg;
    logic       pop;

    assign valid = (cnt_reg != 2'd0);
    assign pop   = valid && !stall;
    assign room  = (cnt_reg != 2'd2);
    assign head  = slot0_reg;

    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_reg == 2'd2 && pop)
            slot0_reg <= slot1_reg;
        else if (push && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
            slot0_reg <= push_res;
        if (push && ((cnt_reg == 2'd1 && !pop) || (cnt_reg == 2'd2 && pop)))
            slot1_reg <= push_res;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg != 2'd2))
        else $error("result pushed into a full queue");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue count out of range");

    a_stalled_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && stall) |=> (valid && $stable(head)))
        else $error("stalled result changed");
`endif

endmodule

// ===== src/sfnt_font_format_sniffer.sv =====
`timescale 1ns / 1ps

// sfnt font format sniffer. A font file arrives one byte per request on the input
// channel, with last marking its final byte; the request carrying last produces
// exactly one result (format: 0 unknown, 1 ttf, 2 otf, 3 ttc, 4 otc, and the font
// count), and the block is then ready for the next file. Throughput is one byte per
// clock while the input is not stalled: each request is held in an input register and
// then processed by a single update stage (position counter, 20-byte header store,
// tag shift register, outline flags, collection signature capture), and the result
// of a last byte is pushed from that update into a two-entry queue. Input stalls
// only while a last byte waits and that queue is full. The table-count limit
// (register 0) and scan window (register 1) are sampled at the first byte of each
// file, so a write takes effect with the next file.

module sfnt_font_format_sniffer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             write_enable,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]    reg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]   write_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       data_byte,
    input  logic                             last,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       format,
    output logic [31:0]                      font_count
);
    import sfs_pkg::*;

    logic       a_valid_reg;
    logic       a_valid_next;
    logic [7:0] a_byte_reg;
    logic       a_last_reg;
    logic       in_accept;
    logic       fire;
    logic       room;
    cfg_wr_t    cfg;
    view_t      view;
    result_t    res;
    result_t    head;

    assign cfg.we    = write_enable;
    assign cfg.index = reg_index;
    assign cfg.data  = write_data;

    // Advance the held byte unless it closes a file and no result slot is free
    assign fire      = a_valid_reg && (!a_last_reg || room);
    assign in_stall  = a_valid_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    assign a_valid_next = in_accept || (a_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    // Hold the request payload until it is processed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_byte_reg <= data_byte;
            a_last_reg <= last;
        end
    end

    sfs_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (fire),
        .data_byte (a_byte_reg),
        .last      (a_last_reg),
        .view      (view)
    );

    sfs_decide u_decide (
        .view (view),
        .res  (res)
    );

    sfs_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fire && a_last_reg),
        .push_res (res),
        .room     (room),
        .valid    (out_valid),
        .stall    (out_stall),
        .head     (head)
    );

    assign format     = head.format;
    assign font_count = head.font_count;

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && a_last_reg) |=> out_valid)
        else $error("last byte processed without a result");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> a_valid_reg)
        else $error("accepted request not held");

    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (a_valid_reg && a_last_reg && !room))
        else $error("input stalled without a full result queue");
`endif

endmodule

// ===== bench/sniff_checker.sv =====
`timescale 1ns / 1ps

module sniff_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           write_enable,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]  reg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0] write_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [7:0]                     data_byte,
    input  logic                           last,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [2:0]                     format,
    input  logic [31:0]                    font_count,
    output int                             fail_count,
    output int                             pending
);
    import sfs_pkg::*;

    localparam logic [31:0] OFFSET_LIMIT = 32'h7FFF_FFFF;

    logic [7:0]  hdr_store [HDR_BYTES];
    logic [31:0] byte_pos;
    logic [31:0] tag_window;
    logic [31:0] coll_sig;
    logic        seen_glyf;
    logic        seen_cff;
    logic [15:0] max_tables_reg;
    logic [15:0] scan_window_reg;
    logic [15:0] max_tables_file;
    logic [15:0] scan_window_file;
    result_t     expected_results [$];

    // Big-endian word from the header store; bytes past the store read as zero
    function automatic logic [31:0] header_word(input longint unsigned at);
        logic [31:0] w;
        w = '0;
        for (int k = 0; k < 4; k++)
        begin
            w = {w[23:0], (at + k < HDR_BYTES) ? hdr_store[at + k] : 8'h00};
        end
        return w;
    endfunction

    function automatic result_t classify_file(input longint unsigned len);
        result_t         r;
        logic [31:0]     sig;
        logic [31:0]     fc;
        logic [31:0]     off;
        logic [31:0]     s;
        longint unsigned ntab;
        longint unsigned need;
        longint unsigned span;
        r.format     = FMT_UNKNOWN;
        r.font_count = '0;
        if (len < 12)
            return r;
        sig = header_word(0);
        if (sig == SIG_TTCF)
        begin
            fc = header_word(8);
            if (fc == 0 || len < 16)
                return r;
            off = header_word(12);
            if (off > OFFSET_LIMIT || len < 64'(off) + 4)
                return r;
            s = (64'(off) + 4 <= HDR_BYTES) ? header_word(off) : coll_sig;
            r.format     = (s == SIG_OTTO) ? FMT_OTC : FMT_TTC;
            r.font_count = fc;
            return r;
        end
        if (sig == SIG_TT10 || sig == SIG_TRUE)
            r.format = FMT_TTF;
        else if (sig == SIG_OTTO)
            r.format = FMT_OTF;
        else
            return r;
        r.font_count = 32'd1;
        ntab = header_word(4) >> 16;
        if (ntab == 0 || ntab > max_tables_file)
            return r;
        need = DIR_START + ntab * ENTRY_BYTES;
        span = (need > scan_window_file) ? scan_window_file : need;
        if (span < DIR_START + ENTRY_BYTES || len < span)
            return r;
        if (seen_glyf && !seen_cff)
            r.format = FMT_TTF;
        else if (seen_cff && !seen_glyf)
            r.format = FMT_OTF;
        return r;
    endfunction

    task automatic absorb_byte(input logic [7:0] b, input logic lst);
        logic [31:0]     p;
        logic [31:0]     off;
        longint unsigned idx;
        longint unsigned ntab;
        p = byte_pos;
        if (p == 0)
        begin
            foreach (hdr_store[k])
                hdr_store[k] = 8'h00;
            tag_window       = '0;
            coll_sig         = '0;
            seen_glyf        = 1'b0;
            seen_cff         = 1'b0;
            max_tables_file  = max_tables_reg;
            scan_window_file = scan_window_reg;
        end
        if (p < HDR_BYTES)
            hdr_store[p] = b;
        tag_window = {tag_window[23:0], b};

        // Last byte of a directory entry tag
        if (p >= DIR_START + 3 && ((p - DIR_START - 3) % ENTRY_BYTES) == 0)
        begin
            idx  = (p - DIR_START - 3) / ENTRY_BYTES;
            ntab = header_word(4) >> 16;
            if (idx < ntab && DIR_START + (idx + 1) * ENTRY_BYTES <= scan_window_file)
            begin
                if (tag_window == GLYF_TAG)
                    seen_glyf = 1'b1;
                else if (tag_window == CFF_TAG || tag_window == CFF2_TAG)
                    seen_cff = 1'b1;
            end
        end

        if (p >= 16)
        begin
            off = header_word(12);
            if (p >= off && p - off < 4)
                coll_sig = {coll_sig[23:0], b};
        end

        if (lst)
        begin
            expected_results.push_back(classify_file(64'(p) + 1));
            byte_pos = '0;
        end
        else if (p != POS_MAX)
            byte_pos = p + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            byte_pos        = '0;
            max_tables_reg  = MAX_TABLES_RST;
            scan_window_reg = SCAN_WINDOW_RST;
            max_tables_file = MAX_TABLES_RST;
            scan_window_file = SCAN_WINDOW_RST;
            tag_window      = '0;
            coll_sig        = '0;
            seen_glyf       = 1'b0;
            seen_cff        = 1'b0;
            foreach (hdr_store[k])
                hdr_store[k] = 8'h00;
            expected_results.delete();
            fail_count      = 0;
            pending         = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual format %0d count %0h",
                             $time, format, font_count);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (format !== want.format)
                    begin
                        $display("%0t: format mismatch: expected %0d, actual %0d",
                                 $time, want.format, format);
                        fail_count++;
                    end
                    if (font_count !== want.font_count)
                    begin
                        $display("%0t: font_count mismatch: expected %0h, actual %0h",
                                 $time, want.font_count, font_count);
                        fail_count++;
                    end
                end
            end

            if (write_enable)
            begin
                if (reg_index == REG_MAX_TABLES)
                    max_tables_reg = write_data;
                else if (reg_index == REG_SCAN_WINDOW)
                    scan_window_reg = write_data;
            end

            if (in_valid && !in_stall)
                absorb_byte(data_byte, last);

            pending = expected_results.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the sfnt sniffer. Font images are built in a byte
// queue and streamed one request per byte; the checker beside the block
// predicts and compares every result.

module tb;
    import sfs_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  write_enable;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] write_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            data_byte;
    logic                  last;
    logic                  out_valid;
    logic                  out_stall;
    logic [2:0]            format;
    logic [31:0]           font_count;
    int                    fail_count;
    int                    pending;

    // Current idling mix, in percent per cycle
    int unsigned idle_pct;
    int unsigned stall_pct;

    // Register values in force, so the generator can aim at the limits
    int unsigned cur_max;
    int unsigned cur_win;

    // The font image being built for the next file
    logic [7:0] image [$];

    sfnt_font_format_sniffer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .format       (format),
        .font_count   (font_count)
    );

    sniff_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .format       (format),
        .font_count   (font_count),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("** sfnt_font_format_sniffer: FAILED **");
        $finish;
    end

    // Receiver: stall the result channel at random, changing on the falling edge
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Offer one byte; hold it until the request is taken at a rising edge.
    // Drop valid only while idling, so it is never lowered and raised in one step.
    task automatic drive_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= lst;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic stream_image();
        for (int i = 0; i < image.size(); i++)
            drive_byte(image[i], i == image.size() - 1);
    endtask

    // Hold off new requests until every expected result has come, then settle
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // Write both registers on consecutive cycles; only called while idle
    task automatic set_config(input logic [15:0] max_tables, input logic [15:0] window);
        write_enable <= 1'b1;
        reg_index    <= REG_MAX_TABLES;
        write_data   <= max_tables;
        @(negedge clk);
        reg_index    <= REG_SCAN_WINDOW;
        write_data   <= window;
        @(negedge clk);
        write_enable <= 1'b0;
        cur_max = 32'(max_tables);
        cur_win = 32'(window);
    endtask

    task automatic push_word(input logic [31:0] w);
        image.push_back(w[31:24]);
        image.push_back(w[23:16]);
        image.push_back(w[15:8]);
        image.push_back(w[7:0]);
    endtask

    task automatic push_half(input logic [15:0] h);
        image.push_back(h[15:8]);
        image.push_back(h[7:0]);
    endtask

    task automatic push_rand(input int unsigned n);
        repeat (n) image.push_back(8'($urandom()));
    endtask

    task automatic push_fill(input logic [7:0] b, input int unsigned n);
        repeat (n) image.push_back(b);
    endtask

    // One directory entry: tag, then checksum, offset and length at random
    task automatic push_entry(input logic [31:0] tag);
        push_word(tag);
        push_rand(12);
    endtask

    task automatic start_image(input logic [31:0] sig);
        image.delete();
        push_word(sig);
    endtask

    function automatic logic [31:0] random_tag();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 3)
            return GLYF_TAG;
        else if (pick < 5)
            return CFF_TAG;
        else if (pick < 7)
            return CFF2_TAG;
        else if (pick == 7)
            return GLYF_TAG ^ (32'd1 << $urandom_range(31));
        else
            return $urandom();
    endfunction

    function automatic logic [31:0] random_sig();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 3)
            return SIG_TT10;
        else if (pick < 6)
            return SIG_OTTO;
        else if (pick < 8)
            return SIG_TRUE;
        else
            return $urandom();
    endfunction

    // Mostly well-formed fonts and collections with random content; the rest noise
    task automatic random_image();
        int unsigned kind;
        int unsigned pick;
        int unsigned ntab;
        int unsigned len;
        logic [31:0] count;
        logic [31:0] off;
        kind = $urandom_range(99);
        if (kind < 60)
        begin
            start_image(random_sig());
            pick = $urandom_range(19);
            if (pick == 0)
                ntab = 0;
            else if (pick == 1)
                ntab = $urandom_range(65535);
            else if (pick == 2)
                ntab = cur_max + $urandom_range(1);
            else
                ntab = $urandom_range(1, 6);
            push_half(16'(ntab));
            push_rand(6);
            // Keep the directory short, now and then long enough to hit the window
            if ($urandom_range(15) == 0)
                len = 12 + 16 * ((ntab & 16'hFFFF) > 40 ? 40 : (ntab & 16'hFFFF));
            else
                len = 12 + 16 * ((ntab & 16'hFFFF) > 8 ? 8 : (ntab & 16'hFFFF));
            if ($urandom_range(9) == 0)
                len = $urandom_range(12, len);
            else
                len = len + $urandom_range(8);
            while (image.size() < len)
                push_entry(random_tag());
            while (image.size() > len)
                void'(image.pop_back());
        end
        else if (kind < 85)
        begin
            start_image(SIG_TTCF);
            push_rand(4);
            pick = $urandom_range(7);
            if (pick == 0)
                count = '0;
            else if (pick == 1)
                count = $urandom();
            else
                count = $urandom_range(1, 4);
            push_word(count);
            pick = $urandom_range(9);
            if (pick < 4)
                off = $urandom_range(19);
            else if (pick < 7)
                off = $urandom_range(20, 64);
            else if (pick == 7)
                off = {1'b1, 31'($urandom())};
            else if (pick == 8)
                off = $urandom();
            else
                off = 32'h7FFF_FFFF;
            push_word(off);
            if (off >= 16 && off <= 64)
            begin
                push_rand(off - 16);
                push_word(random_sig());
            end
            if ($urandom_range(5) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    if (image.size() > 1)
                        void'(image.pop_back());
            end
            else
                push_rand($urandom_range(6));
        end
        else
        begin
            image.delete();
            push_rand($urandom_range(1, 40));
        end
    endtask

    initial
    begin
        in_valid     = 1'b0;
        data_byte    = 8'h00;
        last         = 1'b0;
        write_enable = 1'b0;
        reg_index    = REG_MAX_TABLES;
        write_data   = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        cur_max      = 32'(MAX_TABLES_RST);
        cur_win      = 32'(SCAN_WINDOW_RST);
        rst_n        = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed files, at the reset register values and with no idling.

        // One byte, and eleven bytes behind a good signature: both too short
        image.delete();
        image.push_back(8'hFF);
        stream_image();
        start_image(SIG_TT10);
        push_rand(7);
        stream_image();

        // Unknown signature
        start_image(32'hDEAD_BEEF);
        push_rand(8);
        stream_image();

        // All-zero and all-ones files
        image.delete();
        push_fill(8'h00, 16);
        stream_image();
        image.delete();
        push_fill(8'hFF, 16);
        stream_image();

        // Zero tables: the signature decides despite a glyf tag
        start_image(SIG_OTTO);
        push_half(16'd0);
        push_rand(6);
        push_entry(GLYF_TAG);
        stream_image();

        // A lone CFF table under a TrueType signature
        start_image(SIG_TT10);
        push_half(16'd1);
        push_rand(6);
        push_entry(CFF_TAG);
        stream_image();

        // A lone glyf table under OTTO
        start_image(SIG_OTTO);
        push_half(16'd1);
        push_rand(6);
        push_entry(GLYF_TAG);
        stream_image();

        // Both outline kinds: the signature decides
        start_image(SIG_TRUE);
        push_half(16'd2);
        push_rand(6);
        push_entry(GLYF_TAG);
        push_entry(CFF2_TAG);
        stream_image();

        // CFF2 among other tables
        start_image(SIG_TRUE);
        push_half(16'd3);
        push_rand(6);
        push_entry(32'h6865_6164);
        push_entry(CFF2_TAG);
        push_entry(32'h6C6F_6361);
        stream_image();

        // Table count above the limit
        start_image(SIG_OTTO);
        push_half(16'd101);
        push_rand(6);
        push_entry(GLYF_TAG);
        stream_image();

        // Directory cut short of its size
        start_image(SIG_TT10);
        push_half(16'd2);
        push_rand(6);
        push_entry(CFF_TAG);
        push_rand(4);
        stream_image();

        // Empty collection
        start_image(SIG_TTCF);
        push_rand(4);
        push_word(0);
        push_word(16);
        push_word(SIG_OTTO);
        stream_image();

        // Collection under 16 bytes
        start_image(SIG_TTCF);
        push_rand(4);
        push_word(2);
        push_rand(3);
        stream_image();

        // Offset above the limit, and right at it with too few bytes
        start_image(SIG_TTCF);
        push_rand(4);
        push_word(1);
        push_word(32'h8000_0000);
        push_rand(8);
        stream_image();
        start_image(SIG_TTCF);
        push_rand(4);
        push_word(1);
        push_word(32'h7FFF_FFFF);
        push_rand(8);
        stream_image();

        // OTTO inside the header store, straddling its end, and beyond it
        start_image(SIG_TTCF);
        push_rand(4);
        push_word(2);
        push_word(16);
        push_word(SIG_OTTO);
        stream_image();
        start_image(SIG_TTCF);
        push_rand(4);
        push_word(3);
        push_word(17);
        push_rand(1);
        push_word(SIG_OTTO);
        stream_image();
        start_image(SIG_TTCF);
        push_rand(4);
        push_word(5);
        push_word(24);
        push_rand(8);
        push_word(SIG_OTTO);
        stream_image();

        // One byte short of offset plus four
        start_image(SIG_TTCF);
        push_rand(4);
        push_word(1);
        push_word(24);
        push_rand(11);
        stream_image();

        // Non-OTTO signature at the offset gives ttc; offset zero reads ttcf itself
        start_image(SIG_TTCF);
        push_rand(4);
        push_word(32'hFFFF_FFFF);
        push_word(24);
        push_rand(8);
        push_word(SIG_TRUE);
        stream_image();
        start_image(SIG_TTCF);
        push_rand(4);
        push_word(1);
        push_word(0);
        stream_image();

        drain(4);

        // Random phases: each sets the registers while idle, then streams files
        // under one idling mix until enough bytes and results have gone through.
        for (int phase = 0; phase < 4; phase++)
        begin : phases
            int unsigned sent_bytes;
            int unsigned sent_files;
            case (phase)
                0:       set_config(16'd1, 16'd28);
                1:       set_config(16'hFFFF, 16'hFFFF);
                2:       set_config(16'd3, 16'd60);
                default: set_config(16'($urandom_range(1, 12)), 16'($urandom_range(28, 140)));
            endcase
            case (phase % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 87;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 87;
                end
                default:
                begin
                    idle_pct  = 16;
                    stall_pct = 16;
                end
            endcase
            sent_bytes = 0;
            sent_files = 0;
            while (sent_files < 1 || sent_bytes < 40)
            begin
                random_image();
                stream_image();
                sent_bytes += image.size();
                sent_files++;
                // Now and then let the block run dry before the next file
                if ($urandom_range(7) == 0)
                    drain(4);
            end
            drain(4);
        end

        // Wait out the tail, then give the verdict
        drain(8);
        if (fail_count == 0 && pending == 0)
            $display("** sfnt_font_format_sniffer: PASSED **");
        else
            $display("** sfnt_font_format_sniffer: FAILED **");
        $finish;
    end

endmodule

// ===== sfnt_font_format_sniffer.f =====
src/sfs_pkg.sv
src/sfs_scan.sv
src/sfs_decide.sv
src/sfs_outq.sv
src/sfnt_font_format_sniffer.sv
bench/sniff_checker.sv
bench/tb.sv
